/* hw/rtl/lbbc_pkg.sv */
// Shared types and constants for the LRU block buffer cache.
package lbbc_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int RANK_W = SLOT_W;

    localparam logic [7:0] REF_MAX = 8'hFF;

    typedef enum logic [1:0] {
        CMD_GET       = 2'd0,
        CMD_RELEASE   = 2'd1,
        CMD_SET_FLAGS = 2'd2,
        CMD_NOP       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_BUF  = 2'd1,
        ST_REL_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic lookup;
        logic select;
        logic commit;
    } t_dp_cmd;

endpackage

/* hw/rtl/lru_block_buffer_cache_core.sv */
// Top level of the LRU block buffer cache.
// Each request (get, release, set flags or nop) passes through the cycle in which it is
// accepted, the parallel tag compare across all slots, the recency priority select, and the
// update of the slot table, which also loads the result register. The input stall stays high
// from acceptance through the update cycle, so a new request is taken only after the previous
// one has been committed; a waiting result holds the update cycle until the result register is
// free. No clearing pass is needed after reset.
module lru_block_buffer_cache_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_device,
    input  logic [31:0] i_block_number,
    input  logic [3:0]  i_slot,
    input  logic        i_new_valid,
    input  logic        i_new_dirty,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_result_slot,
    output logic        o_hit,
    output logic        o_need_read,
    output logic [7:0]  o_refs_left,
    output logic [1:0]  o_status
);

    lbbc_pkg::t_dp_cmd dp_cmd;

    lbbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    lbbc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_req_cmd      (i_cmd),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .i_new_valid    (i_new_valid),
        .i_new_dirty    (i_new_dirty),
        .o_result_slot  (o_result_slot),
        .o_hit          (o_hit),
        .o_need_read    (o_need_read),
        .o_refs_left    (o_refs_left),
        .o_status       (o_status)
    );

endmodule

/* hw/rtl/lbbc_ctrl.sv */
// Request sequencer: steps a request through lookup, select and update.
module lbbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lbbc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SELECT,
        S_UPDATE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_in_stall;
    logic   accept;
    logic   commit;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign commit = (r_state == S_UPDATE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        o_cmd.load   = accept;
        o_cmd.lookup = (r_state == S_LOOKUP);
        o_cmd.select = (r_state == S_SELECT);
        o_cmd.commit = commit;
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_in_stall  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= S_LOOKUP;
                        r_in_stall <= 1'b1;
                    end
                end
                S_LOOKUP: r_state <= S_SELECT;
                S_SELECT: r_state <= S_UPDATE;
                S_UPDATE: begin
                    if (commit) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("result not presented after update");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> !(r_out_valid && i_out_stall))
        else $error("pending result overwritten");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && r_state == S_LOOKUP))
        else $error("accepted request not in flight");

endmodule

/* hw/rtl/lbbc_datapath.sv */
// Slot table, tag match, recency select and update logic.
module lbbc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lbbc_pkg::t_dp_cmd  i_cmd,
    input  logic [1:0]         i_req_cmd,
    input  logic [7:0]         i_device,
    input  logic [31:0]        i_block_number,
    input  logic [3:0]         i_slot,
    input  logic               i_new_valid,
    input  logic               i_new_dirty,
    output logic [3:0]         o_result_slot,
    output logic               o_hit,
    output logic               o_need_read,
    output logic [7:0]         o_refs_left,
    output logic [1:0]         o_status
);

    localparam int N  = lbbc_pkg::SLOTS;
    localparam int SW = lbbc_pkg::SLOT_W;
    localparam int RW = lbbc_pkg::RANK_W;

    // request
    lbbc_pkg::t_cmd r_cmd;
    logic [7:0]     r_dev;
    logic [31:0]    r_blk;
    logic [3:0]     r_slot;
    logic           r_nv;
    logic           r_nd;

    // slot table
    logic [7:0]    r_tag_dev [N];
    logic [31:0]   r_tag_blk [N];
    logic [7:0]    r_count   [N];
    logic          r_valid   [N];
    logic          r_dirty   [N];
    logic [RW-1:0] r_rank    [N];

    logic [7:0]    n_tag_dev [N];
    logic [31:0]   n_tag_blk [N];
    logic [7:0]    n_count   [N];
    logic          n_valid   [N];
    logic          n_dirty   [N];
    logic [RW-1:0] n_rank    [N];

    // lookup / select
    logic [N-1:0]  r_match_rank;
    logic [N-1:0]  r_free_rank;
    logic [N-1:0]  n_match_rank;
    logic [N-1:0]  n_free_rank;
    logic [RW-1:0] r_sel_rank;
    logic          r_hit;
    logic          r_found;
    logic [RW-1:0] sel_lo;
    logic [RW-1:0] sel_hi;

    // update
    logic [SW-1:0] sel_idx;
    logic [SW-1:0] tgt;
    logic          in_range;
    logic [7:0]    cnt;
    logic [7:0]    cnt_dec;
    logic [RW-1:0] old_rank;

    logic [3:0]    n_res_slot;
    logic          n_res_hit;
    logic          n_res_nr;
    logic [7:0]    n_res_refs;
    logic [1:0]    n_res_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= lbbc_pkg::t_cmd'(i_req_cmd);
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_slot <= i_slot;
            r_nv   <= i_new_valid;
            r_nd   <= i_new_dirty;
        end
    end

    // Match and free vectors reindexed by recency rank.
    always_comb begin
        n_match_rank = '0;
        n_free_rank  = '0;
        for (int i = 0; i < N; i++) begin
            if (r_tag_dev[i] == r_dev && r_tag_blk[i] == r_blk) begin
                n_match_rank[r_rank[i]] = 1'b1;
            end
            if (r_count[i] == 8'd0 && !r_dirty[i]) begin
                n_free_rank[r_rank[i]] = 1'b1;
            end
        end
    end

    always_comb begin
        sel_lo = '0;
        sel_hi = '0;
        for (int r = N - 1; r >= 0; r--) begin
            if (r_match_rank[r]) begin
                sel_lo = RW'(r);
            end
        end
        for (int r = 0; r < N; r++) begin
            if (r_free_rank[r]) begin
                sel_hi = RW'(r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_match_rank <= n_match_rank;
            r_free_rank  <= n_free_rank;
        end
        if (i_cmd.select) begin
            r_hit      <= |r_match_rank;
            r_found    <= |r_free_rank;
            r_sel_rank <= (|r_match_rank) ? sel_lo : sel_hi;
        end
    end

    always_comb begin
        sel_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (r_rank[i] == r_sel_rank) begin
                sel_idx = SW'(i);
            end
        end
    end

    assign in_range = (int'(r_slot) < N);
    assign tgt      = (r_cmd == lbbc_pkg::CMD_GET) ? sel_idx : SW'(r_slot);
    assign cnt      = r_count[tgt];
    assign cnt_dec  = cnt - 8'd1;
    assign old_rank = r_rank[tgt];

    always_comb begin
        n_tag_dev    = r_tag_dev;
        n_tag_blk    = r_tag_blk;
        n_count      = r_count;
        n_valid      = r_valid;
        n_dirty      = r_dirty;
        n_rank       = r_rank;
        n_res_slot   = '0;
        n_res_hit    = 1'b0;
        n_res_nr     = 1'b0;
        n_res_refs   = '0;
        n_res_status = lbbc_pkg::ST_OK;
        case (r_cmd)
            lbbc_pkg::CMD_GET: begin
                if (r_hit) begin
                    n_count[tgt] = (cnt == lbbc_pkg::REF_MAX) ? cnt : cnt + 8'd1;
                    n_res_slot   = 4'(tgt);
                    n_res_hit    = 1'b1;
                    n_res_nr     = !r_valid[tgt];
                    n_res_refs   = n_count[tgt];
                end else if (r_found) begin
                    n_tag_dev[tgt] = r_dev;
                    n_tag_blk[tgt] = r_blk;
                    n_valid[tgt]   = 1'b0;
                    n_dirty[tgt]   = 1'b0;
                    n_count[tgt]   = 8'd1;
                    n_res_slot     = 4'(tgt);
                    n_res_nr       = 1'b1;
                    n_res_refs     = 8'd1;
                end else begin
                    n_res_status = lbbc_pkg::ST_NO_BUF;
                end
            end
            lbbc_pkg::CMD_RELEASE: begin
                n_res_slot = r_slot;
                if (!in_range || cnt == 8'd0) begin
                    n_res_status = lbbc_pkg::ST_REL_ERR;
                end else begin
                    n_count[tgt] = cnt_dec;
                    n_res_refs   = cnt_dec;
                    if (cnt_dec == 8'd0) begin
                        // drop to zero: move slot to the front
                        for (int i = 0; i < N; i++) begin
                            if (r_rank[i] < old_rank) begin
                                n_rank[i] = r_rank[i] + RW'(1);
                            end
                        end
                        n_rank[tgt] = '0;
                    end
                end
            end
            lbbc_pkg::CMD_SET_FLAGS: begin
                n_res_slot = r_slot;
                if (in_range) begin
                    n_valid[tgt] = r_nv;
                    n_dirty[tgt] = r_nd;
                    n_res_refs   = cnt;
                end
            end
            lbbc_pkg::CMD_NOP: begin
                n_res_slot = '0;
            end
            default: begin
                n_res_slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_tag_dev[i] <= '0;
                r_tag_blk[i] <= '0;
                r_count[i]   <= '0;
                r_valid[i]   <= 1'b0;
                r_dirty[i]   <= 1'b0;
                r_rank[i]    <= RW'(N - 1 - i);
            end
        end else if (i_cmd.commit) begin
            r_tag_dev <= n_tag_dev;
            r_tag_blk <= n_tag_blk;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_dirty   <= n_dirty;
            r_rank    <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_result_slot <= n_res_slot;
            o_hit         <= n_res_hit;
            o_need_read   <= n_res_nr;
            o_refs_left   <= n_res_refs;
            o_status      <= n_res_status;
        end
    end

endmodule

/* test/tb_lru_block_buffer_cache_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LRU block buffer cache core: directed and random requests.
module tb_lru_block_buffer_cache_core;

    localparam int SLOTS           = lbbc_pkg::SLOTS;
    localparam int RANK_W          = lbbc_pkg::RANK_W;
    localparam int QUIET_LIMIT     = 2000;
    localparam int RANDOM_REQUESTS = 560;
    localparam int SATURATE_GETS   = 260;
    localparam int TAG_POOL        = 20;

    typedef struct packed {
        logic [3:0]        slot;
        logic              hit;
        logic              need_read;
        logic [7:0]        refs;
        lbbc_pkg::t_status status;
    } t_cache_result;

    class buffer_cache_scoreboard;
        logic [7:0]        tag_dev[SLOTS];
        logic [31:0]       tag_blk[SLOTS];
        logic [7:0]        refs[SLOTS];
        logic              valid_bit[SLOTS];
        logic              dirty_bit[SLOTS];
        logic [RANK_W-1:0] rank[SLOTS];
        t_cache_result     expected_results[$];
        int                mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                tag_dev[i]   = '0;
                tag_blk[i]   = '0;
                refs[i]      = '0;
                valid_bit[i] = 1'b0;
                dirty_bit[i] = 1'b0;
                rank[i]      = RANK_W'(SLOTS - 1 - i);
            end
            mismatches = 0;
        endfunction

        function void note_request(lbbc_pkg::t_cmd cmd, logic [7:0] dev, logic [31:0] blk,
                                   logic [3:0] s, logic nv, logic nd);
            int            best;
            int            old;
            t_cache_result want;
            want = '0;
            best = -1;
            case (cmd)
                lbbc_pkg::CMD_GET: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tag_dev[i] == dev && tag_blk[i] == blk &&
                            (best < 0 || rank[i] < rank[best]))
                            best = i;
                    end
                    if (best >= 0) begin
                        if (refs[best] != lbbc_pkg::REF_MAX)
                            refs[best] = refs[best] + 8'd1;
                        want.slot      = best[3:0];
                        want.hit       = 1'b1;
                        want.need_read = !valid_bit[best];
                        want.refs      = refs[best];
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (refs[i] == 0 && !dirty_bit[i] &&
                                (best < 0 || rank[i] > rank[best]))
                                best = i;
                        end
                        if (best < 0) begin
                            want.status = lbbc_pkg::ST_NO_BUF;
                        end else begin
                            tag_dev[best]   = dev;
                            tag_blk[best]   = blk;
                            valid_bit[best] = 1'b0;
                            dirty_bit[best] = 1'b0;
                            refs[best]      = 8'd1;
                            want.slot       = best[3:0];
                            want.need_read  = 1'b1;
                            want.refs       = 8'd1;
                        end
                    end
                end
                lbbc_pkg::CMD_RELEASE: begin
                    want.slot = s;
                    if (refs[s] == 0) begin
                        want.status = lbbc_pkg::ST_REL_ERR;
                    end else begin
                        refs[s] = refs[s] - 8'd1;
                        if (refs[s] == 0) begin
                            old = int'(rank[s]);
                            for (int i = 0; i < SLOTS; i++) begin
                                if (rank[i] < old)
                                    rank[i] = rank[i] + 1'b1;
                            end
                            rank[s] = '0;
                        end
                        want.refs = refs[s];
                    end
                end
                lbbc_pkg::CMD_SET_FLAGS: begin
                    valid_bit[s] = nv;
                    dirty_bit[s] = nd;
                    want.slot    = s;
                    want.refs    = refs[s];
                end
                default: ;
            endcase
            expected_results.push_back(want);
        endfunction

        function void check_result(t_cache_result got);
            t_cache_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: slot %0d hit %0b read %0b refs %0d status %0d",
                             got.slot, got.hit, got.need_read, got.refs, got.status);
                return;
            end
            want = expected_results.pop_front();
            if (got.slot != want.slot || got.hit != want.hit ||
                got.need_read != want.need_read || got.refs != want.refs ||
                got.status != want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected slot %0d hit %0b read %0b refs %0d status %0d,",
                              " got slot %0d hit %0b read %0b refs %0d status %0d"},
                             want.slot, want.hit, want.need_read, want.refs, want.status,
                             got.slot, got.hit, got.need_read, got.refs, got.status);
            end
        endfunction

        function bit can_get(logic [7:0] dev, logic [31:0] blk);
            for (int i = 0; i < SLOTS; i++) begin
                if ((tag_dev[i] == dev && tag_blk[i] == blk) || (refs[i] == 0 && !dirty_bit[i]))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit pick_referenced(inout logic [3:0] s);
            int start;
            int j;
            start = $urandom_range(SLOTS - 1);
            for (int i = 0; i < SLOTS; i++) begin
                j = (start + i) % SLOTS;
                if (refs[j] != 0) begin
                    s = j[3:0];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic [3:0] dirty_slot();
            for (int i = 0; i < SLOTS; i++) begin
                if (dirty_bit[i])
                    return i[3:0];
            end
            return '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function bit failed();
            return mismatches != 0 || expected_results.size() != 0;
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_cmd          = '0;
    logic [7:0]  i_device       = '0;
    logic [31:0] i_block_number = '0;
    logic [3:0]  i_slot         = '0;
    logic        i_new_valid    = 1'b0;
    logic        i_new_dirty    = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [3:0]  o_result_slot;
    logic        o_hit;
    logic        o_need_read;
    logic [7:0]  o_refs_left;
    logic [1:0]  o_status;

    buffer_cache_scoreboard sb;
    bit                     no_idle = 1'b0;
    int                     quiet_cycles = 0;
    logic [7:0]             pool_dev[TAG_POOL];
    logic [31:0]            pool_blk[TAG_POOL];

    always #10 i_clk = ~i_clk;

    lru_block_buffer_cache_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .i_new_valid    (i_new_valid),
        .i_new_dirty    (i_new_dirty),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_slot  (o_result_slot),
        .o_hit          (o_hit),
        .o_need_read    (o_need_read),
        .o_refs_left    (o_refs_left),
        .o_status       (o_status)
    );

    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 35);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{slot: o_result_slot, hit: o_hit, need_read: o_need_read,
                              refs: o_refs_left,
                              status: lbbc_pkg::t_status'(o_status)});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb_lru_block_buffer_cache_core failed");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input lbbc_pkg::t_cmd cmd, input logic [7:0] dev,
                                input logic [31:0] blk, input logic [3:0] s,
                                input logic nv, input logic nd);
        while (!no_idle && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_device       <= dev;
        i_block_number <= blk;
        i_slot         <= s;
        i_new_valid    <= nv;
        i_new_dirty    <= nd;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_request(cmd, dev, blk, s, nv, nd);
    endtask

    initial begin
        int          pick;
        int          k;
        bit          fill;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [3:0]  s;
        sb = new();
        for (int i = 0; i < TAG_POOL; i++) begin
            pool_dev[i] = 8'($urandom_range(3));
            pool_blk[i] = 32'($urandom_range(31));
        end
        pool_dev[0] = '0;
        pool_blk[0] = '0;
        pool_dev[1] = 8'hFF;
        pool_blk[1] = 32'hFFFF_FFFF;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset tags are (0,0): hits the most recent slot
        send_request(lbbc_pkg::CMD_GET, 8'h00, 32'h0000_0000, 4'h0, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 4'h0, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_GET, 8'h00, 32'h0000_0000, 4'h0, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_SET_FLAGS, 8'h00, 32'h0, 4'd0, 1'b1, 1'b0);
        send_request(lbbc_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 4'h0, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 4'd0, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 4'd0, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 4'd0, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 4'd15, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 4'd15, 1'b0, 1'b0);
        send_request(lbbc_pkg::CMD_SET_FLAGS, 8'h00, 32'h0, 4'd15, 1'b1, 1'b1);
        send_request(lbbc_pkg::CMD_SET_FLAGS, 8'h00, 32'h0, 4'd3, 1'b0, 1'b1);
        send_request(lbbc_pkg::CMD_NOP, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1);
        // fill every clean slot, the last get finds no free buffer
        for (int i = 0; i < 15; i++)
            send_request(lbbc_pkg::CMD_GET, 8'(i + 1), 32'h1 << (2 * i), 4'h0, 1'b0, 1'b0);

        for (int r = 0; r < RANDOM_REQUESTS; r++) begin
            if (r == 400) begin
                dev = 8'h5A;
                blk = 32'hA5A5_0001;
                while (!sb.can_get(dev, blk)) begin
                    if (sb.pick_referenced(s))
                        send_request(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, s, 1'b0, 1'b0);
                    else
                        send_request(lbbc_pkg::CMD_SET_FLAGS, 8'h00, 32'h0, sb.dirty_slot(),
                                     1'b1, 1'b0);
                end
                // drive the reference count into saturation
                repeat (SATURATE_GETS)
                    send_request(lbbc_pkg::CMD_GET, dev, blk, 4'h0, 1'b0, 1'b0);
            end
            no_idle = (r >= 200 && r < 350);
            fill = ((r / 60) % 2) == 0;
            pick = $urandom_range(99);
            dev  = 8'($urandom_range(255));
            blk  = $urandom;
            s    = 4'($urandom_range(15));
            if (pick < (fill ? 60 : 30)) begin
                k = $urandom_range(TAG_POOL - 1);
                if ($urandom_range(9) == 0) begin
                    pool_dev[k] = dev;
                    pool_blk[k] = blk;
                end
                if ($urandom_range(19) != 0) begin
                    dev = pool_dev[k];
                    blk = pool_blk[k];
                end
                send_request(lbbc_pkg::CMD_GET, dev, blk, s, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end else if (pick < (fill ? 80 : 75)) begin
                if ($urandom_range(99) < 85)
                    void'(sb.pick_referenced(s));
                send_request(lbbc_pkg::CMD_RELEASE, dev, blk, s, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end else if (pick < 95) begin
                send_request(lbbc_pkg::CMD_SET_FLAGS, dev, blk, s, 1'($urandom_range(1)),
                             $urandom_range(99) < 30);
            end else begin
                send_request(lbbc_pkg::CMD_NOP, dev, blk, s, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failed())
            $display("tb_lru_block_buffer_cache_core failed");
        else
            $display("tb_lru_block_buffer_cache_core passed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lbbc_pkg.sv
hw/rtl/lbbc_ctrl.sv
hw/rtl/lbbc_datapath.sv
hw/rtl/lru_block_buffer_cache_core.sv
test/tb_lru_block_buffer_cache_core.sv
